// ----- sv/cbt_pkg.sv -----
package cbt_pkg;

  localparam int COORD_W         = 16;
  localparam int CNT_W           = 6;
  localparam int WID_W           = 8;
  localparam int T_W             = 17;
  localparam int REM_W           = CNT_W + 1;
  localparam int DIV_CNT_W       = 5;
  localparam int Q_DEPTH         = 2;
  localparam int Q_AW            = 1;
  localparam int MAX_SEGMENTS_DEF = 63;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  typedef struct packed {
    logic [3:0][COORD_W-1:0] px;
    logic [3:0][COORD_W-1:0] py;
    logic [CNT_W-1:0]        seg_n;
    logic [WID_W-1:0]        width;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [WID_W-1:0]   width;
    logic               last;
  } seg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL_A,
    BK_MUL_B,
    BK_SUM,
    BK_OUT
  } bk_state_t;

endpackage

// ----- sv/cbt_if.sv -----
interface cbt_in_if import cbt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] p0_x;
  logic signed [COORD_W-1:0] p0_y;
  logic signed [COORD_W-1:0] p1_x;
  logic signed [COORD_W-1:0] p1_y;
  logic signed [COORD_W-1:0] p2_x;
  logic signed [COORD_W-1:0] p2_y;
  logic signed [COORD_W-1:0] p3_x;
  logic signed [COORD_W-1:0] p3_y;
  logic [CNT_W-1:0]          segment_count;
  logic [WID_W-1:0]          line_width;

  modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  segment_count, line_width, input ready);
  modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                segment_count, line_width, output ready);
endinterface

interface cbt_out_if import cbt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] seg_start_x;
  logic signed [COORD_W-1:0] seg_start_y;
  logic signed [COORD_W-1:0] seg_end_x;
  logic signed [COORD_W-1:0] seg_end_y;
  logic [WID_W-1:0]          seg_width;
  logic                      last_segment;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  seg_width, last_segment, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                seg_width, last_segment, output ready);
endinterface

// ----- sv/cubic_bezier_line_tessellator_core.sv -----
// A command passes the front register and the queue, then the 65536/n step
// divider and the point evaluator (MUL_A, MUL_B, SUM, OUT); a command with
// count n gives n+1 lines, and the evaluator waits in OUT while the output is held.
// Commands are taken into a two-entry queue while the evaluator works.
// Reset (rst_n low, synchronous) empties the queue and output register and
// clears the previous point and step index.
module cubic_bezier_line_tessellator_core import cbt_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cbt_in_if.sink    in_ch,
  cbt_out_if.source out_ch
);

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  cmd_t fr_cmd, bk_cmd;

  cbt_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  cbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_cmd)
  );

  cbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_ch    (out_ch)
  );

endmodule

// ----- sv/cbt_front.sv -----
module cbt_front import cbt_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  cbt_in_if.sink  in_ch,
  output logic    cmd_valid,
  input  logic    cmd_ready,
  output cmd_t    cmd
);

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SEGMENTS);

  logic             valid_r, valid_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] n_clamped;
  logic             take;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !valid_r || cmd_ready;

  always_comb begin
    if (in_ch.segment_count == '0) begin
      n_clamped = CNT_W'(1);
    end else if (in_ch.segment_count > MAX_N) begin
      n_clamped = MAX_N;
    end else begin
      n_clamped = in_ch.segment_count;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt     = 1'b1;
      cmd_nxt.px    = {in_ch.p3_x, in_ch.p2_x, in_ch.p1_x, in_ch.p0_x};
      cmd_nxt.py    = {in_ch.p3_y, in_ch.p2_y, in_ch.p1_y, in_ch.p0_y};
      cmd_nxt.seg_n = n_clamped;
      cmd_nxt.width = in_ch.line_width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

// ----- sv/cbt_queue.sv -----
module cbt_queue import cbt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- sv/cbt_back.sv -----
module cbt_back import cbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  cbt_out_if.source out_ch
);

  localparam logic signed [39:0] LO = -(40'sd1 <<< (COORD_W - 1));
  localparam logic signed [39:0] HI = (40'sd1 <<< (COORD_W - 1)) - 40'sd1;

  bk_state_t state_r, state_nxt;
  cmd_t      cmd_r, cmd_nxt;

  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]     div_rem_r, div_rem_nxt;
  logic [T_W-1:0]       div_quo_r, div_quo_nxt;
  logic [T_W-1:0]       q0_r, q0_nxt;
  logic [CNT_W-1:0]     r0_r, r0_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [T_W-1:0]       t_r, t_nxt;
  logic [REM_W-1:0]     tr_r, tr_nxt;

  logic [T_W-1:0]       um_r, tm_r;
  logic [33:0]          uu_r, tt_r;
  logic [3:0][T_W-1:0]  w_r;
  logic [COORD_W-1:0]   ex_r, ey_r;
  logic [COORD_W-1:0]   prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;

  logic                 out_valid_r, out_valid_nxt;
  seg_t                 out_r, out_nxt;

  logic [REM_W-1:0]     rem_sh, r_sum;
  logic                 rem_ge;
  logic [T_W-1:0]       u_cur;
  logic [35:0]          uu3, tt3;
  logic [50:0]          p0_raw, p3_raw;
  logic [52:0]          p1_raw, p2_raw;
  logic [COORD_W-1:0]   cx, cy;
  logic                 out_free, is_last;

  function automatic logic [COORD_W-1:0] eval_coord(input logic [3:0][COORD_W-1:0] p,
                                                    input logic [3:0][T_W-1:0] w);
    logic signed [35:0] acc;
    logic signed [35:0] wk;
    logic signed [35:0] pk;
    logic signed [35:0] sh;
    logic signed [39:0] r;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      wk  = 36'($signed({1'b0, w[k]}));
      pk  = 36'($signed(p[k]));
      acc = acc + wk * pk;
    end
    sh = (acc + 36'sd32768) >>> 16;
    r  = 40'(sh);
    if (r < LO) r = LO;
    if (r > HI) r = HI;
    return r[COORD_W-1:0];
  endfunction

  assign rem_sh   = {div_rem_r, (div_cnt_r == DIV_CNT_W'(T_W - 1))};
  assign rem_ge   = rem_sh >= {1'b0, cmd_r.seg_n};
  assign u_cur    = T_ONE - t_r;
  assign uu3      = {2'b0, uu_r} + {1'b0, uu_r, 1'b0};
  assign tt3      = {2'b0, tt_r} + {1'b0, tt_r, 1'b0};
  assign p0_raw   = 51'(uu_r) * 51'(um_r);
  assign p3_raw   = 51'(tt_r) * 51'(tm_r);
  assign p1_raw   = 53'(uu3) * 53'(tm_r);
  assign p2_raw   = 53'(tt3) * 53'(um_r);
  assign cx       = eval_coord(cmd_r.px, w_r);
  assign cy       = eval_coord(cmd_r.py, w_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_last  = (i_r == cmd_r.seg_n);
  assign r_sum    = tr_r + {1'b0, r0_r};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    div_cnt_nxt   = div_cnt_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    q0_nxt        = q0_r;
    r0_nxt        = r0_r;
    i_nxt         = i_r;
    t_nxt         = t_r;
    tr_nxt        = tr_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_ready     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt     = cmd;
          div_cnt_nxt = DIV_CNT_W'(T_W - 1);
          div_rem_nxt = '0;
          div_quo_nxt = '0;
          state_nxt   = BK_DIV;
        end
      end
      BK_DIV: begin
        div_quo_nxt = {div_quo_r[T_W-2:0], rem_ge};
        div_rem_nxt = rem_ge ? CNT_W'(rem_sh - {1'b0, cmd_r.seg_n}) : CNT_W'(rem_sh);
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          q0_nxt    = div_quo_nxt;
          r0_nxt    = div_rem_nxt;
          t_nxt     = '0;
          tr_nxt    = {2'b0, cmd_r.seg_n[CNT_W-1:1]};
          i_nxt     = '0;
          state_nxt = BK_MUL_A;
        end
      end
      BK_MUL_A: state_nxt = BK_MUL_B;
      BK_MUL_B: state_nxt = BK_SUM;
      BK_SUM:   state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.sx    = (i_r == '0) ? ex_r : prev_x_r;
          out_nxt.sy    = (i_r == '0) ? ey_r : prev_y_r;
          out_nxt.ex    = ex_r;
          out_nxt.ey    = ey_r;
          out_nxt.width = cmd_r.width;
          out_nxt.last  = is_last;
          prev_x_nxt    = ex_r;
          prev_y_nxt    = ey_r;
          if (is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
            if (r_sum >= {1'b0, cmd_r.seg_n}) begin
              t_nxt  = t_r + q0_r + 1'b1;
              tr_nxt = r_sum - {1'b0, cmd_r.seg_n};
            end else begin
              t_nxt  = t_r + q0_r;
              tr_nxt = r_sum;
            end
            state_nxt = BK_MUL_A;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      i_r         <= i_nxt;
    end
    cmd_r     <= cmd_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    q0_r      <= q0_nxt;
    r0_r      <= r0_nxt;
    t_r       <= t_nxt;
    tr_r      <= tr_nxt;
    out_r     <= out_nxt;
    if (state_r == BK_MUL_A) begin
      um_r <= u_cur;
      tm_r <= t_r;
      uu_r <= 34'(u_cur) * 34'(u_cur);
      tt_r <= 34'(t_r) * 34'(t_r);
    end
    if (state_r == BK_MUL_B) begin
      w_r[0] <= T_W'((p0_raw + 51'(33'h080000000)) >> 32);
      w_r[1] <= T_W'((p1_raw + 53'(33'h080000000)) >> 32);
      w_r[2] <= T_W'((p2_raw + 53'(33'h080000000)) >> 32);
      w_r[3] <= T_W'((p3_raw + 51'(33'h080000000)) >> 32);
    end
    if (state_r == BK_SUM) begin
      ex_r <= cx;
      ey_r <= cy;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.seg_start_x  = out_r.sx;
  assign out_ch.seg_start_y  = out_r.sy;
  assign out_ch.seg_end_x    = out_r.ex;
  assign out_ch.seg_end_y    = out_r.ey;
  assign out_ch.seg_width    = out_r.width;
  assign out_ch.last_segment = out_r.last;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import cbt_pkg::*;

  typedef struct {
    cmd_t cmd;
    bit   drain;
  } cmd_slot_t;

  logic clk;
  logic rst_n;

  cbt_in_if  in_ch ();
  cbt_out_if out_ch ();

  cubic_bezier_line_tessellator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cmd_slot_t pending_cmds[$];
  seg_t      expected_lines[$];
  int        errors = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        idle_cycles = 0;
  bit        in_accepted = 1'b0;

  localparam int IDLE_LIMIT = 4000;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [COORD_W-1:0] bezier_coord(logic [T_W-1:0] t,
                                                      logic [3:0][COORD_W-1:0] p);
    longint unsigned u, uu, tt;
    longint unsigned w[4];
    longint sum, r;
    u  = 65536 - t;
    uu = u * u;
    tt = t * t;
    w[0] = (uu * u + (64'd1 << 31)) >> 32;
    w[1] = (3 * uu * t + (64'd1 << 31)) >> 32;
    w[2] = (3 * u * tt + (64'd1 << 31)) >> 32;
    w[3] = (tt * t + (64'd1 << 31)) >> 32;
    sum = 0;
    for (int k = 0; k < 4; k++)
      sum += longint'(w[k]) * longint'($signed(p[k]));
    r = (sum + 32768) >>> 16;
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    return r[COORD_W-1:0];
  endfunction

  task automatic tessellate(cmd_t c);
    int n;
    longint unsigned t;
    seg_t s;
    logic [COORD_W-1:0] prev_x, prev_y;
    n = c.seg_n;
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
    prev_x = bezier_coord('0, c.px);
    prev_y = bezier_coord('0, c.py);
    for (int i = 0; i <= n; i++) begin
      t = (longint'(i) * 65536 + n / 2) / n;
      s.sx    = prev_x;
      s.sy    = prev_y;
      s.ex    = bezier_coord(t[T_W-1:0], c.px);
      s.ey    = bezier_coord(t[T_W-1:0], c.py);
      s.width = c.width;
      s.last  = (i == n);
      expected_lines.push_back(s);
      prev_x = s.ex;
      prev_y = s.ey;
    end
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] exp_v,
                             logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_accepted) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
        in_ch.valid <= 1'b0;
        if (expected_lines.size() == 0) void'(pending_cmds.pop_front());
      end else if (pending_cmds.size() > 0) begin
        cmd_slot_t sl;
        sl = pending_cmds.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.p0_x          <= sl.cmd.px[0];
        in_ch.p0_y          <= sl.cmd.py[0];
        in_ch.p1_x          <= sl.cmd.px[1];
        in_ch.p1_y          <= sl.cmd.py[1];
        in_ch.p2_x          <= sl.cmd.px[2];
        in_ch.p2_y          <= sl.cmd.py[2];
        in_ch.p3_x          <= sl.cmd.px[3];
        in_ch.p3_y          <= sl.cmd.py[3];
        in_ch.segment_count <= sl.cmd.seg_n;
        in_ch.line_width    <= sl.cmd.width;
        in_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    in_accepted <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd_t c;
        c.px[0] = in_ch.p0_x; c.py[0] = in_ch.p0_y;
        c.px[1] = in_ch.p1_x; c.py[1] = in_ch.p1_y;
        c.px[2] = in_ch.p2_x; c.py[2] = in_ch.p2_y;
        c.px[3] = in_ch.p3_x; c.py[3] = in_ch.p3_y;
        c.seg_n = in_ch.segment_count;
        c.width = in_ch.line_width;
        tessellate(c);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lines.size() == 0) begin
          errors++;
          $display("%0t unexpected item actual %h %h %h %h %h %b", $time,
                   out_ch.seg_start_x, out_ch.seg_start_y, out_ch.seg_end_x,
                   out_ch.seg_end_y, out_ch.seg_width, out_ch.last_segment);
        end else begin
          seg_t e;
          e = expected_lines.pop_front();
          check_field("seg_start_x", e.sx, out_ch.seg_start_x);
          check_field("seg_start_y", e.sy, out_ch.seg_start_y);
          check_field("seg_end_x", e.ex, out_ch.seg_end_x);
          check_field("seg_end_y", e.ey, out_ch.seg_end_y);
          check_field("seg_width", 16'(e.width), 16'(out_ch.seg_width));
          check_field("last_segment", 16'(e.last), 16'(out_ch.last_segment));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    return COORD_W'($urandom());
  endfunction

  task automatic add_cmd(cmd_t c);
    cmd_slot_t sl;
    sl.cmd   = c;
    sl.drain = 1'b0;
    pending_cmds.push_back(sl);
  endtask

  task automatic add_drain();
    cmd_slot_t sl;
    sl.cmd   = '0;
    sl.drain = 1'b1;
    pending_cmds.push_back(sl);
  endtask

  initial begin
    cmd_t c;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.p0_x = '0; in_ch.p0_y = '0; in_ch.p1_x = '0; in_ch.p1_y = '0;
    in_ch.p2_x = '0; in_ch.p2_y = '0; in_ch.p3_x = '0; in_ch.p3_y = '0;
    in_ch.segment_count = '0;
    in_ch.line_width = '0;
    out_ch.ready = 1'b0;

    // directed
    c = '0; add_cmd(c);
    c.px = {4{16'h8000}}; c.py = {4{16'h8000}}; c.seg_n = CNT_W'(1); c.width = 8'hff;
    add_cmd(c);
    c.px = {4{16'h7fff}}; c.py = {4{16'h7fff}}; c.seg_n = CNT_W'(63); c.width = '0;
    add_cmd(c);
    c.px = {16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
    c.py = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    c.seg_n = '0; c.width = 8'h55; add_cmd(c);
    c.seg_n = CNT_W'(7); c.width = 8'haa; add_cmd(c);
    c.px = {16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    c.py = {16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
    c.seg_n = CNT_W'(3); add_cmd(c);
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 4; k++) begin
        c.px[k] = rand_coord();
        c.py[k] = rand_coord();
      end
      c.seg_n = CNT_W'((i < 6) ? i : 62 + i - 6);
      c.width = WID_W'($urandom());
      add_cmd(c);
    end
    add_drain();

    // random
    for (int i = 0; i < 250; i++) begin
      for (int k = 0; k < 4; k++) begin
        c.px[k] = rand_coord();
        c.py[k] = rand_coord();
      end
      if ($urandom_range(0, 19) == 0) c.seg_n = CNT_W'($urandom());
      else c.seg_n = CNT_W'($urandom_range(0, 8));
      c.width = WID_W'($urandom());
      add_cmd(c);
      if (i == 120) add_drain();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/cbt_pkg.sv
sv/cbt_if.sv
sv/cbt_front.sv
sv/cbt_queue.sv
sv/cbt_back.sv
sv/cubic_bezier_line_tessellator_core.sv
tb/tb_top.sv
